/* rtl/core/jac_pkg.sv */
package jac_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int OUT_W      = 18;
  localparam int SCALE_W    = 16;
  localparam int DBH_W      = 14;
  localparam int DBL_W      = 15;
  localparam int MODE_W     = 8;
  localparam int SRC_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int FRAC_W  = 14;                 // Q2.14 fraction bits
  localparam int XS_W    = SAMPLE_W + 1;       // sample after edge subtraction
  localparam int MAG_W   = SAMPLE_W;           // magnitude of shifted sample
  localparam int DEN_W   = FRAC_W + 1;         // divisor up to 1.0
  localparam int QUOT_W  = MAG_W + FRAC_W;     // renormalized magnitude
  localparam int PROD_W  = QUOT_W + SCALE_W;   // operand times scale magnitude
  localparam int SCALE_SHIFT = 12;             // Q4.12 scale fraction bits
  localparam int PMAG_W  = PROD_W - SCALE_SHIFT;

  // divider sequencing: two quotient bits per cycle
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_STEPS = QUOT_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // fixed point constants
  localparam logic [DEN_W-1:0]  Q14_ONE   = DEN_W'(1 << FRAC_W);
  localparam logic [QUOT_W-1:0] Q14_ONE_Q = QUOT_W'(1 << FRAC_W);
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DB_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DB_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURBO_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EN_THR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TB_THR     = 3'd6;

  // mode bit positions
  localparam int MB_GATING = 0;
  localparam int MB_EN_LT  = 1;
  localparam int MB_TB_LT  = 2;
  localparam int MB_HOLD   = 3;
  localparam int MB_AXIS   = 4;
  localparam int MB_PLUS   = 5;
  localparam int MB_MINUS  = 6;
  localparam int MB_DB_ON  = 7;

  // register reset values
  localparam logic [MODE_W-1:0]         MODE_RST   = 8'd240;
  localparam logic [DBH_W-1:0]          DBH_RST    = 14'd1311;
  localparam logic signed [DBL_W-1:0]   DBL_RST    = -15'sd1311;
  localparam logic signed [SCALE_W-1:0] NSCALE_RST = 16'sd4096;
  localparam logic signed [SCALE_W-1:0] TSCALE_RST = 16'sd8192;
  localparam logic signed [SAMPLE_W-1:0] THR_RST   = 16'sd8192;

  // result source codes
  localparam logic [SRC_W-1:0] SRC_GATED = 2'd0;
  localparam logic [SRC_W-1:0] SRC_FRESH = 2'd1;
  localparam logic [SRC_W-1:0] SRC_HELD  = 2'd2;

  // beat payloads
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] axis_sample;
    logic                       plus_button;
    logic                       minus_button;
    logic signed [SAMPLE_W-1:0] enable_level;
    logic signed [SAMPLE_W-1:0] turbo_level;
  } in_beat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] axis_out;
    logic [SRC_W-1:0]        source;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_beat_t;

  // divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

/* rtl/core/jac_ifs.sv */
interface jac_in_if import jac_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface jac_out_if import jac_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface jac_cfg_if import jac_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/joystick_axis_conditioner_top.sv */
// a renormalizing sample passes PREP, DINIT, DIV, MUL, SAT and FIN; one that the deadband does
// not renormalize skips DINIT and DIV, and a gated-off sample goes from PREP straight to FIN
// a new sample is taken only in IDLE, after the last result is loaded into the result
// register; the serial divider (two quotient bits per cycle, 15 steps) lengthens the renormalizing path
// reset (rst_n, synchronous): configuration registers return to defaults, held value clears,
// result register empties
module joystick_axis_conditioner_top import jac_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  jac_in_if.sink   in_ch,
  jac_out_if.source out_ch,
  jac_cfg_if.sink  cfg_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_DINIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_SAT   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  // configuration registers
  logic [MODE_W-1:0]          mode_r;
  logic [DBH_W-1:0]           db_high_r;
  logic signed [DBL_W-1:0]    db_low_r;
  logic signed [SCALE_W-1:0]  norm_scale_r;
  logic signed [SCALE_W-1:0]  turbo_scale_r;
  logic signed [SAMPLE_W-1:0] en_thr_r;
  logic signed [SAMPLE_W-1:0] tb_thr_r;

  // sequencer and item registers
  logic [2:0]                 state_r;
  logic [2:0]                 state_nxt;
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       plus_r;
  logic                       minus_r;
  logic signed [SAMPLE_W-1:0] en_level_r;
  logic signed [SAMPLE_W-1:0] tb_level_r;
  logic                       gated_r;
  logic signed [XS_W-1:0]     xs_r;
  logic [QUOT_W-1:0]          opnd_r;
  logic                       neg_r;
  logic [SCALE_W-1:0]         scale_mag_r;
  logic                       neg_scale_r;
  logic [PROD_W-1:0]          prod_r;
  logic signed [OUT_W-1:0]    val_r;
  logic signed [OUT_W-1:0]    held_r;
  logic                       out_valid_r;
  out_beat_t                  out_beat_r;

  // prep stage terms
  logic                       en_act;
  logic                       tb_act;
  logic                       gated;
  logic signed [XS_W-1:0]     x_ext;
  logic signed [XS_W-1:0]     hi_ext;
  logic signed [XS_W-1:0]     lo_ext;
  logic                       ge_hi;
  logic                       le_lo;
  logic                       inband;
  logic signed [XS_W-1:0]     xs;
  logic [MAG_W-1:0]           abs_x;
  logic signed [SCALE_W-1:0]  scale_sel;
  logic [SCALE_W:0]           scale_neg;

  // divider setup terms
  logic [DEN_W-1:0]           den_hi;
  logic signed [DEN_W:0]      low_ext;
  logic [DEN_W:0]             abs_low;
  logic [DEN_W:0]             den_lo_raw;
  logic [DEN_W-1:0]           den_lo;
  logic [XS_W-1:0]            abs_xs;

  // saturation terms
  logic [PMAG_W-1:0]          pmag;
  logic signed [OUT_W-1:0]    sat_val;

  // divider link
  div_ctl_t                   div_ctl;
  div_sts_t                   div_sts;
  logic [QUOT_W-1:0]          quot;

  logic in_fire;
  logic out_fire;
  logic out_load;
  logic store;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid & in_ch.ready;
  assign out_fire     = out_ch.valid & out_ch.ready;
  assign out_load     = (state_r == S_FIN) & (~out_valid_r | out_ch.ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_RST;
      db_high_r     <= DBH_RST;
      db_low_r      <= DBL_RST;
      norm_scale_r  <= NSCALE_RST;
      turbo_scale_r <= TSCALE_RST;
      en_thr_r      <= THR_RST;
      tb_thr_r      <= THR_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.data.index)
        REG_MODE:        mode_r        <= cfg_ch.data.wdata[MODE_W-1:0];
        REG_DB_HIGH:     db_high_r     <= cfg_ch.data.wdata[DBH_W-1:0];
        REG_DB_LOW:      db_low_r      <= $signed(cfg_ch.data.wdata[DBL_W-1:0]);
        REG_NORM_SCALE:  norm_scale_r  <= $signed(cfg_ch.data.wdata);
        REG_TURBO_SCALE: turbo_scale_r <= $signed(cfg_ch.data.wdata);
        REG_EN_THR:      en_thr_r      <= $signed(cfg_ch.data.wdata);
        REG_TB_THR:      tb_thr_r      <= $signed(cfg_ch.data.wdata);
        default: ;
      endcase
    end
  end

  // level compare, gating, deadband edge subtraction, magnitude and scale select
  always_comb begin
    en_act = mode_r[MB_EN_LT] ? (en_level_r < en_thr_r) : (en_level_r > en_thr_r);
    tb_act = mode_r[MB_TB_LT] ? (tb_level_r < tb_thr_r) : (tb_level_r > tb_thr_r);
    gated  = mode_r[MB_GATING] & ~en_act & ~tb_act;
    x_ext  = XS_W'(x_r);
    hi_ext = $signed({{(XS_W-DBH_W){1'b0}}, db_high_r});
    lo_ext = XS_W'(db_low_r);
    ge_hi  = (x_ext >= hi_ext);
    le_lo  = (x_ext <= lo_ext);
    inband = ~ge_hi & ~le_lo;
    if (ge_hi) begin
      xs = x_ext - hi_ext;
    end else begin
      xs = x_ext - lo_ext;
    end
    abs_x     = x_r[SAMPLE_W-1] ? MAG_W'(-x_ext) : MAG_W'(x_ext);
    scale_sel = (mode_r[MB_GATING] & tb_act) ? turbo_scale_r : norm_scale_r;
    scale_neg = -{scale_sel[SCALE_W-1], scale_sel};
  end

  // divisor for each edge and magnitude of the shifted sample
  always_comb begin
    den_hi     = Q14_ONE - {1'b0, db_high_r};
    low_ext    = (DEN_W+1)'(db_low_r);
    abs_low    = low_ext[DEN_W] ? (DEN_W+1)'(-low_ext) : (DEN_W+1)'(low_ext);
    den_lo_raw = {1'b0, Q14_ONE} - abs_low;
    den_lo     = (den_lo_raw == '0) ? DEN_W'(1) : den_lo_raw[DEN_W-1:0];
    abs_xs     = xs_r[XS_W-1] ? XS_W'(-xs_r) : XS_W'(xs_r);
  end

  assign div_ctl.start = (state_r == S_DINIT);

  jac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (abs_xs[MAG_W-1:0]),
    .divisor  ((xs_r > 0) ? den_hi : den_lo),
    .sts      (div_sts),
    .quotient (quot)
  );

  // sign, shift by the scale fraction and saturate
  always_comb begin
    pmag = prod_r[PROD_W-1:SCALE_SHIFT];
    if (neg_r ^ neg_scale_r) begin
      if (pmag >= PMAG_W'(1 << (OUT_W-1))) begin
        sat_val = OUT_MIN;
      end else begin
        sat_val = -$signed(pmag[OUT_W-1:0]);
      end
    end else begin
      if (pmag > PMAG_W'(OUT_MAX)) begin
        sat_val = OUT_MAX;
      end else begin
        sat_val = $signed(pmag[OUT_W-1:0]);
      end
    end
  end

  // hold decision
  assign store = plus_r | minus_r | (mode_r[MB_AXIS] & (~mode_r[MB_HOLD] | (val_r != '0)));

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (gated) begin
          state_nxt = S_FIN;
        end else if (plus_r | minus_r | ~mode_r[MB_DB_ON] | inband) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DINIT;
        end
      end
      S_DINIT: state_nxt = S_DIV;
      S_DIV: begin
        if (div_sts.done) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_SAT;
      S_SAT: state_nxt = S_FIN;
      S_FIN: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (out_load && !gated_r && store) begin
        held_r <= val_r;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r        <= mode_r[MB_AXIS] ? in_ch.data.axis_sample : '0;
      plus_r     <= mode_r[MB_PLUS] & in_ch.data.plus_button;
      minus_r    <= mode_r[MB_MINUS] & in_ch.data.minus_button;
      en_level_r <= in_ch.data.enable_level;
      tb_level_r <= in_ch.data.turbo_level;
    end
    if (state_r == S_PREP) begin
      gated_r     <= gated;
      xs_r        <= xs;
      neg_scale_r <= scale_sel[SCALE_W-1];
      scale_mag_r <= scale_sel[SCALE_W-1] ? scale_neg[SCALE_W-1:0] : $unsigned(scale_sel);
      // buttons override, then raw magnitude or a zero from inside the deadband
      if (plus_r | minus_r) begin
        opnd_r <= (plus_r & minus_r) ? '0 : Q14_ONE_Q;
        neg_r  <= minus_r & ~plus_r;
      end else if (!mode_r[MB_DB_ON]) begin
        opnd_r <= QUOT_W'(abs_x);
        neg_r  <= x_r[SAMPLE_W-1];
      end else begin
        opnd_r <= '0;
        neg_r  <= 1'b0;
      end
    end
    if (state_r == S_DINIT) begin
      neg_r <= xs_r[XS_W-1];
    end
    if (state_r == S_DIV && div_sts.done) begin
      opnd_r <= quot;
    end
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(opnd_r) * PROD_W'(scale_mag_r);
    end
    if (state_r == S_SAT) begin
      val_r <= sat_val;
    end
    if (out_load) begin
      if (gated_r) begin
        out_beat_r.axis_out <= '0;
        out_beat_r.source   <= SRC_GATED;
      end else if (store || !mode_r[MB_HOLD]) begin
        out_beat_r.axis_out <= val_r;
        out_beat_r.source   <= SRC_FRESH;
      end else begin
        out_beat_r.axis_out <= held_r;
        out_beat_r.source   <= SRC_HELD;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_beat_r;

endmodule

/* rtl/core/jac_div.sv */
module jac_div import jac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_ctl_t          ctl,
  input  logic [MAG_W-1:0]  dividend,
  input  logic [DEN_W-1:0]  divisor,
  output div_sts_t          sts,
  output logic [QUOT_W-1:0] quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     rem_nxt;
  logic [QUOT_W-1:0]    dvd_r;
  logic [QUOT_W-1:0]    dvd_nxt;
  logic [DEN_W-1:0]     den_r;

  // two restoring steps per cycle, quotient bits shift in behind the dividend
  always_comb begin
    logic [DEN_W:0] r2;
    logic           ge;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      r2 = {rem_nxt, dvd_nxt[QUOT_W-1]};
      ge = (r2 >= {1'b0, den_r});
      rem_nxt = ge ? DEN_W'(r2 - {1'b0, den_r}) : DEN_W'(r2);
      dvd_nxt = {dvd_nxt[QUOT_W-2:0], ge};
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      dvd_r <= {dividend, {FRAC_W{1'b0}}};
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign sts.done = done_r;
  assign quotient = dvd_r;

endmodule
